// ===== hdl/prt_pkg.sv =====
`default_nettype none

package prt_pkg;

   localparam int TIME_W  = 32;
   localparam int TALLY_W = 16;
   localparam int SPEED_W = 16;
   localparam int SCALE_W = 24;
   localparam int MS_W    = 16;
   localparam int CSR_W   = 2;
   localparam int DIV_W   = 32;
   localparam int STEP_W  = $clog2(DIV_W);
   localparam int PROD_W  = DIV_W + SCALE_W;

   localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
   localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

   localparam logic [SCALE_W-1:0] SCALE_RESET    = 24'd234721;
   localparam logic [MS_W-1:0]    INTERVAL_RESET = 16'd200;
   localparam logic [MS_W-1:0]    TIMEOUT_RESET  = 16'd1000;

   // counts at or above this use the coarse dividend/divisor pair
   localparam logic [TALLY_W-1:0] TALLY_COARSE = 16'd256;
   localparam int FINE_SHIFT   = 23;
   localparam int COARSE_SHIFT = 16;
   localparam int ELAPSED_DROP = 7;
   localparam int FRAC_W       = 16;

   typedef enum logic {
      ACT_PULSE = 1'b0,
      ACT_READ  = 1'b1
   } action_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_SCALE    = 2'd0,
      CSR_INTERVAL = 2'd1,
      CSR_TIMEOUT  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCALE,
      ST_FINISH
   } prt_state_type;

   // divider handshake
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== hdl/prt_divider.sv =====
`default_nettype none

module prt_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire prt_pkg::div_ctrl_type       ctrl,
   input  wire logic [prt_pkg::DIV_W-1:0]   dividend,
   input  wire logic [prt_pkg::DIV_W-1:0]   divisor,
   output prt_pkg::div_status_type          status,
   output logic [prt_pkg::DIV_W-1:0]        quotient
);
   import prt_pkg::*;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [DIV_W-1:0]    den_ff, den_in;
   logic [DIV_W:0]      trial;
   logic [DIV_W+1:0]    diff;
   logic                fits;

   // one restoring step: shift in the next dividend bit, try the subtract
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff  = {1'b0, trial} - {2'b00, den_ff};
      fits  = ~diff[DIV_W+1];
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = busy_ff && (step_ff == STEP_LAST);
   assign quotient    = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      status.done |=> !busy_ff)
      else $error("divider still busy after done");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |=> busy_ff && (step_ff == '0))
      else $error("divider did not begin at step zero");

endmodule

`default_nettype wire

// ===== hdl/prt_scaler.sv =====
`default_nettype none

module prt_scaler (
   input  wire logic                          clock,
   input  wire logic                          load,
   input  wire logic [prt_pkg::DIV_W-1:0]     rate,
   input  wire logic [prt_pkg::SCALE_W-1:0]   scale,
   output logic [prt_pkg::SPEED_W-1:0]        speed
);
   import prt_pkg::*;

   logic [PROD_W-1:0] prod_ff, prod_in;

   always_comb begin
      prod_in = prod_ff;
      if (load) begin
         prod_in = PROD_W'(rate) * PROD_W'(scale);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // drop the Q16 fraction, clamp anything above 16 bits
   always_comb begin
      if (|prod_ff[PROD_W-1:FRAC_W+SPEED_W]) begin
         speed = SPEED_MAX;
      end else begin
         speed = prod_ff[FRAC_W+SPEED_W-1:FRAC_W];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pulse_rate_tachometer.sv =====
`default_nettype none

// Engine speed meter. A pulse item (action 0) stores its microsecond time and
// bumps a saturating pulse count; it gives no result.
// A read item (action 1) gives one speed result. When more than
// update_interval_ms have passed since the last update and two or more pulses
// were counted, the rate is recomputed: a 32-step restoring divider followed
// by one multiply with the Q8.16 scale and a clamp to 16 bits, so such a read
// holds req_stall while divider and scaler run. Every other read, and a zero
// divisor, is answered without the divider. Only one item is worked on at a time;
// req_stall is also high while a result waits on rsp_stall. Configuration
// writes are always ready and must be made while the block is idle.
module pulse_rate_tachometer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_action,
   input  wire logic [prt_pkg::TIME_W-1:0]    req_time_us,
   input  wire logic [prt_pkg::TIME_W-1:0]    req_time_ms,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [prt_pkg::SPEED_W-1:0]        rsp_speed,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [prt_pkg::CSR_W-1:0]     csr_index,
   input  wire logic [prt_pkg::SCALE_W-1:0]   csr_data
);
   import prt_pkg::*;

   prt_state_type        state_ff, state_in;

   logic [SCALE_W-1:0]   scale_ff, scale_in;
   logic [MS_W-1:0]      interval_ff, interval_in;
   logic [MS_W-1:0]      timeout_ff, timeout_in;

   logic [TALLY_W-1:0]   tally_ff, tally_in;
   logic [TIME_W-1:0]    last_pulse_ff, last_pulse_in;
   logic [TIME_W-1:0]    last_used_ff, last_used_in;
   logic [TIME_W-1:0]    last_update_ff, last_update_in;
   logic [SPEED_W-1:0]   held_ff, held_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 req_accept;
   logic                 is_read;
   logic [TIME_W-1:0]    since;
   logic                 due;
   logic                 stopped;
   logic                 enough;
   logic                 coarse;
   logic [TIME_W-1:0]    elapsed;
   logic [DIV_W-1:0]     dividend;
   logic [DIV_W-1:0]     divisor;
   logic                 div_zero;
   logic                 launch;

   div_ctrl_type         div_ctrl;
   div_status_type       div_status;
   logic [DIV_W-1:0]     quotient;
   logic                 scale_load;
   logic [SPEED_W-1:0]   scaled_speed;

   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign is_read    = (req_action == ACT_READ);
   assign csr_ready  = 1'b1;

   always_comb begin
      since    = req_time_ms - last_update_ff;
      due      = since > TIME_W'(interval_ff);
      stopped  = since > TIME_W'(timeout_ff);
      enough   = tally_ff > TALLY_W'(1);
      coarse   = tally_ff >= TALLY_COARSE;
      elapsed  = last_pulse_ff - last_used_ff;
      if (coarse) begin
         dividend = DIV_W'({tally_ff, {COARSE_SHIFT{1'b0}}});
         divisor  = DIV_W'(elapsed >> ELAPSED_DROP);
      end else begin
         dividend = DIV_W'({tally_ff[7:0], {FINE_SHIFT{1'b0}}});
         divisor  = DIV_W'(elapsed);
      end
      div_zero = (divisor == '0);
      launch   = req_accept && is_read && due && enough && !div_zero;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (launch) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      tally_in       = tally_ff;
      last_pulse_in  = last_pulse_ff;
      last_used_in   = last_used_ff;
      last_update_in = last_update_ff;
      held_in        = held_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      div_ctrl.start = 1'b0;
      scale_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && !is_read) begin
               last_pulse_in = req_time_us;
               if (tally_ff != TALLY_MAX) begin
                  tally_in = tally_ff + 1'b1;
               end
            end else if (req_accept) begin
               if (due) begin
                  tally_in = '0;
                  if (enough) begin
                     last_used_in   = last_pulse_ff;
                     last_update_in = req_time_ms;
                     if (div_zero) begin
                        held_in = SPEED_MAX;
                     end
                  end else if (tally_ff == '0 && stopped) begin
                     held_in        = '0;
                     last_update_in = req_time_ms;
                  end
               end
               div_ctrl.start = launch;
               rsp_valid_in   = !launch;
            end
         end
         ST_DIVIDE: begin
         end
         ST_SCALE: begin
            scale_load = 1'b1;
         end
         ST_FINISH: begin
            held_in      = scaled_speed;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      scale_in    = scale_ff;
      interval_in = interval_ff;
      timeout_in  = timeout_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCALE:    scale_in    = csr_data;
            CSR_INTERVAL: interval_in = csr_data[MS_W-1:0];
            CSR_TIMEOUT:  timeout_in  = csr_data[MS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         scale_ff       <= SCALE_RESET;
         interval_ff    <= INTERVAL_RESET;
         timeout_ff     <= TIMEOUT_RESET;
         tally_ff       <= '0;
         last_pulse_ff  <= '0;
         last_used_ff   <= '0;
         last_update_ff <= '0;
         held_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         scale_ff       <= scale_in;
         interval_ff    <= interval_in;
         timeout_ff     <= timeout_in;
         tally_ff       <= tally_in;
         last_pulse_ff  <= last_pulse_in;
         last_used_ff   <= last_used_in;
         last_update_ff <= last_update_in;
         held_ff        <= held_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   prt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (dividend),
      .divisor  (divisor),
      .status   (div_status),
      .quotient (quotient)
   );

   prt_scaler u_scaler (
      .clock (clock),
      .load  (scale_load),
      .rate  (quotient),
      .scale (scale_ff),
      .speed (scaled_speed)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_speed = held_ff;

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result pending during recalculation");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside divide state");

   a_divide_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> div_status.busy)
      else $error("divide state with idle divider");

   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> rsp_valid_ff)
      else $error("recalculated speed not presented");

   a_tally_sat: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_read && tally_ff == TALLY_MAX) |=> (tally_ff == TALLY_MAX))
      else $error("pulse count wrapped");

endmodule

`default_nettype wire
